// ===== sv/wrt_pkg.sv =====
// Shared types, constants and codes of the windowed request tracker.
`timescale 1ns / 1ps
`default_nettype none

package wrt_pkg;

	// Window size and sequence number width.
	localparam int SLOTS      = 4;
	localparam int SEQ_BITS   = 16;
	localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ACT_MAX    = 7;

	// Event codes carried in the cmd field.
	typedef enum logic [1:0] {
		CMD_KICK    = 2'd0,
		CMD_CONTENT = 2'd1,
		CMD_TIMEOUT = 2'd2
	} cmd_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_NEW  = 2'd0,
		KIND_RETX = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	// One incoming event.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [1:0]  slot;
		logic [15:0] content_seq;
		logic        name_match;
		logic [31:0] fresh_nonce;
	} wrt_req_t;

	// One result.
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  out_slot;
		logic [15:0] request_seq;
		logic [31:0] request_nonce;
		logic [2:0]  active_slots;
		logic        task_done;
		logic [31:0] retry_total;
		logic [31:0] disorder_total;
	} wrt_res_t;

	// Lookup results from the slot table.
	typedef struct packed {
		logic                  sel_armed;
		logic [SEQ_BITS-1:0]   sel_number;
		logic                  hit;
		logic [SLOT_IDX_W-1:0] hit_idx;
	} slot_lookup_t;

	// One write into the slot table; live sets both held and armed.
	typedef struct packed {
		logic                  en;
		logic [SLOT_IDX_W-1:0] idx;
		logic                  wr_number;
		logic [SEQ_BITS-1:0]   number;
		logic                  live;
	} slot_update_t;

endpackage

`default_nettype wire

// ===== sv/wrt_if.sv =====
// Handshake interfaces for the request, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface wrt_req_if;
	import wrt_pkg::*;
	logic     valid;
	logic     ready;
	wrt_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wrt_res_if;
	import wrt_pkg::*;
	logic     valid;
	logic     ready;
	wrt_res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wrt_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/wrt_slot_table.sv =====
// Slot table: held number, held and armed flags per slot, plus the content lookup.
`timescale 1ns / 1ps
`default_nettype none

module wrt_slot_table (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire [wrt_pkg::SLOT_IDX_W-1:0]    sel_idx,
	input  wire [wrt_pkg::SEQ_BITS-1:0]      match_seq,
	input  wrt_pkg::slot_update_t            upd,
	output wrt_pkg::slot_lookup_t            lkp
);
	import wrt_pkg::*;

	logic [SEQ_BITS-1:0] number_q [SLOTS];
	logic [SLOTS-1:0]    holds_q;
	logic [SLOTS-1:0]    armed_q;

	// Flags are control state and clear on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holds_q <= '0;
			armed_q <= '0;
		end else if (upd.en) begin
			holds_q[upd.idx] <= upd.live;
			armed_q[upd.idx] <= upd.live;
		end
	end

	// Numbers are only read while held, so they need no reset.
	always_ff @(posedge clk) begin
		if (upd.en && upd.wr_number) begin
			number_q[upd.idx] <= upd.number;
		end
	end

	// Read the addressed slot and find the lowest held slot with the number.
	always_comb begin
		lkp.sel_armed  = armed_q[sel_idx];
		lkp.sel_number = number_q[sel_idx];
		lkp.hit        = 1'b0;
		lkp.hit_idx    = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (holds_q[i] && (number_q[i] == match_seq)) begin
				lkp.hit     = 1'b1;
				lkp.hit_idx = SLOT_IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/windowed_request_tracker.sv =====
// Top level of the windowed request tracker.
`timescale 1ns / 1ps
`default_nettype none

// The tracker keeps a window of request slots and turns kick, content and
// timeout events into new requests, retransmissions and slot-ended reports,
// at most one result per event. It accepts one request per clock cycle while
// the result channel is not stalled; each request passes through the input
// register and then the result register before it appears on the result
// channel. The rate is set by the single state update that an event may make
// to the slot table and counters. Events that cause no result still pass
// through the input register. The final_seq register must only be written
// while the tracker is idle.
module windowed_request_tracker (
	input  wire        clk,
	input  wire        arst_n,
	wrt_cfg_if.sink    cfg,
	wrt_req_if.sink    req,
	wrt_res_if.source  res
);
	import wrt_pkg::*;

	logic [15:0]         final_seq_q;
	logic [SEQ_BITS:0]   next_number_q;
	logic [SEQ_BITS-1:0] prev_arrival_q;
	logic [2:0]          active_q;
	logic [31:0]         retry_q;
	logic [31:0]         disorder_q;

	logic                req_valid_s1;
	wrt_req_t            req_s1;
	logic                res_valid_q;
	wrt_res_t            res_q;

	slot_lookup_t        lkp;
	slot_update_t        upd;
	logic [SLOT_IDX_W-1:0] sel_idx;
	logic [SEQ_BITS-1:0] content_seq;
	logic                slot_ok;
	logic                exhausted;
	logic                has_res;
	logic                advance;
	logic                out_free;
	wrt_res_t            res_d;
	logic [SEQ_BITS:0]   next_number_d;
	logic [SEQ_BITS-1:0] prev_arrival_d;
	logic [2:0]          active_d;
	logic [31:0]         retry_d;
	logic [31:0]         disorder_d;

	// Configuration register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_seq_q <= '0;
		end else if (cfg.valid) begin
			final_seq_q <= cfg.data;
		end
	end

	// Handshake: a request leaves the input register once its result has room.
	assign out_free  = !res_valid_q || res.ready;
	assign advance   = req_valid_s1 && (!has_res || out_free);
	assign req.ready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			req_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	// Slot table with lookup by slot index and by content number.
	assign sel_idx     = SLOT_IDX_W'(req_s1.slot);
	assign content_seq = SEQ_BITS'(req_s1.content_seq);

	wrt_slot_table u_slot_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.sel_idx   (sel_idx),
		.match_seq (content_seq),
		.upd       (upd),
		.lkp       (lkp)
	);

	assign slot_ok   = 32'(req_s1.slot) < 32'(SLOTS);
	assign exhausted = next_number_q > (SEQ_BITS + 1)'(final_seq_q);

	// Event decode: result and next state for the request in the input register.
	always_comb begin
		has_res        = 1'b0;
		upd            = '0;
		next_number_d  = next_number_q;
		prev_arrival_d = prev_arrival_q;
		active_d       = active_q;
		retry_d        = retry_q;
		disorder_d     = disorder_q;
		res_d          = '0;
		res_d.out_slot = req_s1.slot;
		res_d.request_nonce = req_s1.fresh_nonce;

		case (req_s1.cmd)
			CMD_KICK: begin
				if (slot_ok && !exhausted && !lkp.sel_armed) begin
					has_res           = 1'b1;
					upd.en            = 1'b1;
					upd.idx           = sel_idx;
					upd.wr_number     = 1'b1;
					upd.number        = next_number_q[SEQ_BITS-1:0];
					upd.live          = 1'b1;
					next_number_d     = next_number_q + 1'b1;
					if (active_q != 3'(ACT_MAX)) begin
						active_d = active_q + 3'd1;
					end
					res_d.kind        = KIND_NEW;
					res_d.request_seq = 16'(next_number_q[SEQ_BITS-1:0]);
				end
			end
			CMD_TIMEOUT: begin
				if (slot_ok && lkp.sel_armed) begin
					has_res           = 1'b1;
					retry_d           = retry_q + 32'd1;
					res_d.kind        = KIND_RETX;
					res_d.request_seq = 16'(lkp.sel_number);
				end
			end
			CMD_CONTENT: begin
				if (req_s1.name_match && lkp.hit) begin
					has_res        = 1'b1;
					prev_arrival_d = content_seq;
					if (content_seq != (prev_arrival_q + 1'b1)) begin
						disorder_d = disorder_q + 32'd1;
					end
					upd.en         = 1'b1;
					upd.idx        = lkp.hit_idx;
					res_d.out_slot = 2'(lkp.hit_idx);
					if (exhausted) begin
						// Nothing left to fetch: the slot ends.
						upd.live            = 1'b0;
						if (active_q != 3'd0) begin
							active_d = active_q - 3'd1;
						end
						res_d.kind          = KIND_END;
						res_d.request_seq   = 16'(content_seq);
						res_d.request_nonce = '0;
					end else begin
						// The slot takes the next number at once.
						upd.live          = 1'b1;
						upd.wr_number     = 1'b1;
						upd.number        = next_number_q[SEQ_BITS-1:0];
						next_number_d     = next_number_q + 1'b1;
						res_d.kind        = KIND_NEW;
						res_d.request_seq = 16'(next_number_q[SEQ_BITS-1:0]);
					end
				end
			end
			default: begin
				has_res = 1'b0;
			end
		endcase

		upd.en               = upd.en && advance;
		res_d.active_slots   = active_d;
		res_d.task_done      = (res_d.kind == KIND_END) && (active_d == 3'd0);
		res_d.retry_total    = retry_d;
		res_d.disorder_total = disorder_d;
	end

	// Tracker state is committed when the request leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_number_q  <= '0;
			prev_arrival_q <= '1;
			active_q       <= '0;
			retry_q        <= '0;
			disorder_q     <= '0;
		end else if (advance) begin
			next_number_q  <= next_number_d;
			prev_arrival_q <= prev_arrival_d;
			active_q       <= active_d;
			retry_q        <= retry_d;
			disorder_q     <= disorder_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_q <= res_d;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

endmodule

`default_nettype wire

// ===== sv/wrt_checker.sv =====
// Port-level checks on the tracker's result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wrt_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                res_valid,
	input wire                res_ready,
	input wrt_pkg::wrt_res_t  res_data
);
	import wrt_pkg::*;

	// Task done is only reported on a slot end that leaves no slot active.
	a_done_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.task_done |->
			(res_data.kind == KIND_END) && (res_data.active_slots == 3'd0))
		else $error("task_done on a result that is not the last slot end");

	// A slot end carries no nonce.
	a_end_no_nonce: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.kind == KIND_END) |-> res_data.request_nonce == 32'd0)
		else $error("slot end result carries a nonce");

	// Active slots never exceed the window size.
	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(res_data.active_slots) <= 32'(SLOTS))
		else $error("more active slots than the window holds");

	// A stalled result holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("stalled result changed or dropped");

endmodule

bind windowed_request_tracker wrt_checker u_wrt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

`default_nettype wire

// ===== tb/wrt_tracker_check.sv =====
// Checker that predicts the tracker's results from observed requests and compares them.
`timescale 1ns / 1ps

module wrt_tracker_check (
	input  logic                            clk,
	input  logic                            arst_n,
	wrt_cfg_if                              cfg,
	wrt_req_if                              req,
	wrt_res_if                              res,
	output int                              fail_count,
	output int                              waiting,
	output logic [16:0]                     next_hint,
	output logic [wrt_pkg::SLOTS-1:0]       held_hint,
	output logic [wrt_pkg::SLOTS-1:0][15:0] number_hint
);
	import wrt_pkg::*;

	// Predicted tracker state and configuration.
	logic [15:0]       final_number;
	logic [16:0]       next_num;
	logic [15:0]       slot_num [SLOTS];
	logic [SLOTS-1:0]  slot_live;
	logic [SLOTS-1:0]  slot_armed;
	logic [15:0]       last_arrival;
	logic [2:0]        live_count;
	logic [31:0]       retries;
	logic [31:0]       disorders;

	// Packed copy of the slot numbers for the stimulus side.
	logic [SLOTS-1:0][15:0] numbers_now;

	// Results predicted but not yet seen on the result channel.
	wrt_res_t          pending_results [$];
	wrt_res_t          predicted;

	initial fail_count = 0;

	// Apply one request to the predicted state; returns 1 when it yields a result.
	function automatic bit track_event(input wrt_req_t ev, output wrt_res_t r);
		int hit;
		r = '0;
		hit = -1;
		case (ev.cmd)
			CMD_KICK: begin
				if (int'(ev.slot) >= SLOTS || next_num > {1'b0, final_number} ||
						slot_armed[ev.slot])
					return 1'b0;
				slot_num[ev.slot] = next_num[15:0];
				slot_live[ev.slot] = 1'b1;
				slot_armed[ev.slot] = 1'b1;
				next_num = next_num + 17'd1;
				if (live_count < 3'(ACT_MAX))
					live_count = live_count + 3'd1;
				r.kind = KIND_NEW;
				r.out_slot = ev.slot;
				r.request_seq = slot_num[ev.slot];
				r.request_nonce = ev.fresh_nonce;
			end
			CMD_TIMEOUT: begin
				if (int'(ev.slot) >= SLOTS || !slot_armed[ev.slot])
					return 1'b0;
				retries = retries + 32'd1;
				r.kind = KIND_RETX;
				r.out_slot = ev.slot;
				r.request_seq = slot_num[ev.slot];
				r.request_nonce = ev.fresh_nonce;
			end
			CMD_CONTENT: begin
				if (!ev.name_match)
					return 1'b0;
				// The lowest slot holding the number wins.
				for (int i = SLOTS - 1; i >= 0; i--) begin
					if (slot_live[i] && slot_num[i] == ev.content_seq)
						hit = i;
				end
				if (hit < 0)
					return 1'b0;
				if (ev.content_seq != 16'(last_arrival + 16'd1))
					disorders = disorders + 32'd1;
				last_arrival = ev.content_seq;
				slot_armed[hit] = 1'b0;
				r.out_slot = 2'(hit);
				if (next_num > {1'b0, final_number}) begin
					// Nothing left to issue, so the slot ends.
					slot_live[hit] = 1'b0;
					if (live_count > 3'd0)
						live_count = live_count - 3'd1;
					r.kind = KIND_END;
					r.request_seq = ev.content_seq;
					r.request_nonce = '0;
					r.task_done = (live_count == 3'd0);
				end else begin
					slot_num[hit] = next_num[15:0];
					slot_armed[hit] = 1'b1;
					next_num = next_num + 17'd1;
					r.kind = KIND_NEW;
					r.request_seq = slot_num[hit];
					r.request_nonce = ev.fresh_nonce;
				end
			end
			default: return 1'b0;
		endcase
		r.active_slots = live_count;
		r.retry_total = retries;
		r.disorder_total = disorders;
		return 1'b1;
	endfunction

	// Report one field that differs from its prediction.
	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", field, want, got);
			fail_count++;
		end
	endfunction

	// Watch all three channels; results are compared before new requests are predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_number = '0;
			next_num = '0;
			for (int i = 0; i < SLOTS; i++)
				slot_num[i] = '0;
			slot_live = '0;
			slot_armed = '0;
			last_arrival = '1;
			live_count = '0;
			retries = '0;
			disorders = '0;
			pending_results.delete();
		end else begin
			if (cfg.valid && cfg.ready)
				final_number = cfg.data;
			if (res.valid && res.ready) begin
				if (pending_results.size() == 0) begin
					$error("Result with no prediction waiting: %p", res.data);
					fail_count++;
				end else begin
					predicted = pending_results.pop_front();
					check_field("kind", 32'(predicted.kind), 32'(res.data.kind));
					check_field("out_slot", 32'(predicted.out_slot),
						32'(res.data.out_slot));
					check_field("request_seq", 32'(predicted.request_seq),
						32'(res.data.request_seq));
					check_field("request_nonce", predicted.request_nonce,
						res.data.request_nonce);
					check_field("active_slots", 32'(predicted.active_slots),
						32'(res.data.active_slots));
					check_field("task_done", 32'(predicted.task_done),
						32'(res.data.task_done));
					check_field("retry_total", predicted.retry_total, res.data.retry_total);
					check_field("disorder_total", predicted.disorder_total,
						res.data.disorder_total);
				end
			end
			if (req.valid && req.ready && track_event(req.data, predicted))
				pending_results.push_back(predicted);
		end
		// Snapshots for the stimulus side, updated once per edge.
		for (int i = 0; i < SLOTS; i++)
			numbers_now[i] = slot_num[i];
		waiting <= pending_results.size();
		next_hint <= next_num;
		held_hint <= slot_live;
		number_hint <= numbers_now;
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the tracker testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;
	import wrt_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         ITEMS      = 1750;
	localparam int         DRAIN_MAX  = 2000;

	logic                   clk;
	logic                   arst_n;
	int                     fail_count;
	int                     waiting;
	logic [16:0]            next_hint;
	logic [SLOTS-1:0]       held_hint;
	logic [SLOTS-1:0][15:0] number_hint;
	int                     stall_mode;

	wrt_cfg_if cfg_ch ();
	wrt_req_if req_ch ();
	wrt_res_if res_ch ();

	windowed_request_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.res    (res_ch)
	);

	wrt_tracker_check tracker_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.req         (req_ch),
		.res         (res_ch),
		.fail_count  (fail_count),
		.waiting     (waiting),
		.next_hint   (next_hint),
		.held_hint   (held_hint),
		.number_hint (number_hint)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Idle cycles before one transfer; mode 0 never idles.
	function automatic int draw_gap();
		case (stall_mode)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
			default: return int'($urandom_range(0, 18));
		endcase
	endfunction

	// Offer one request and hold it until the tracker takes it.
	task automatic send_event(input logic [1:0] cmd, input logic [1:0] slot,
			input logic [15:0] seq, input logic match, input logic [31:0] nonce);
		wrt_req_t ev;
		int gap;
		ev.cmd = cmd;
		ev.slot = slot;
		ev.content_seq = seq;
		ev.name_match = match;
		ev.fresh_nonce = nonce;
		gap = draw_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= ev;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Stop requests and let every predicted result arrive, plus the pipeline latency.
	task automatic drain();
		int cycles;
		req_ch.valid <= 1'b0;
		cycles = 0;
		do begin
			@(posedge clk);
			cycles++;
		end while (waiting != 0 && cycles < DRAIN_MAX);
		repeat (4) @(posedge clk);
	endtask

	// Write final_seq once the tracker is idle.
	task automatic write_final(input logic [15:0] value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Result side: stall a random number of cycles before each result.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// Reset, directed cases, random phases and the verdict.
	initial begin
		int counted;
		int n;
		int r;
		int s;
		int phase;
		logic [16:0] upper;
		logic [15:0] final_value;

		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		res_ch.ready <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		stall_mode = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Only number zero may be issued.
		write_final(16'd0);
		send_event(CMD_UNUSED, 2'd0, 16'd0, 1'b1, 32'h1234_5678);
		send_event(CMD_TIMEOUT, 2'd0, 16'd0, 1'b0, 32'h0);
		send_event(CMD_CONTENT, 2'd0, 16'd0, 1'b1, 32'h0);
		send_event(CMD_KICK, 2'd0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		send_event(CMD_KICK, 2'd0, 16'd0, 1'b0, 32'h0);
		send_event(CMD_KICK, 2'd1, 16'd0, 1'b0, 32'h0);
		send_event(CMD_TIMEOUT, 2'd0, 16'hFFFF, 1'b1, 32'h0);
		send_event(CMD_CONTENT, 2'd3, 16'd0, 1'b0, 32'hFFFF_FFFF);
		// In-order arrival that wraps from all ones and finishes the task.
		send_event(CMD_CONTENT, 2'd3, 16'd0, 1'b1, 32'hFFFF_FFFF);

		// Whole number space open: fill every slot, arrive out of order, retransmit.
		write_final(16'hFFFF);
		for (int i = 0; i < SLOTS; i++)
			send_event(CMD_KICK, 2'(i), 16'(i), 1'b0, $urandom());
		send_event(CMD_CONTENT, 2'd1, 16'd3, 1'b1, $urandom());
		send_event(CMD_CONTENT, 2'd2, 16'hFFFF, 1'b1, $urandom());
		send_event(CMD_TIMEOUT, 2'd3, 16'd0, 1'b0, $urandom());
		send_event(CMD_CONTENT, 2'd0, 16'd1, 1'b1, $urandom());

		// Close the window at 7 and end every slot.
		write_final(16'd7);
		send_event(CMD_CONTENT, 2'd0, 16'd4, 1'b1, $urandom());
		send_event(CMD_CONTENT, 2'd0, 16'd2, 1'b1, $urandom());
		send_event(CMD_CONTENT, 2'd0, 16'd5, 1'b1, $urandom());
		send_event(CMD_CONTENT, 2'd0, 16'd6, 1'b1, $urandom());
		send_event(CMD_CONTENT, 2'd0, 16'd7, 1'b1, $urandom());

		// Random phases, each with its own window end and idling mode.
		counted = 0;
		phase = 0;
		while (counted < ITEMS) begin
			phase++;
			stall_mode = phase % 3;
			drain();
			r = $urandom_range(0, 9);
			if (r == 0) begin
				final_value = 16'd0;
			end else if (r == 1) begin
				final_value = 16'hFFFF;
			end else begin
				upper = next_hint + 17'($urandom_range(0, 40));
				final_value = (upper > 17'hFFFF) ? 16'hFFFF : upper[15:0];
			end
			write_final(final_value);
			n = $urandom_range(40, 160);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
					// Kick, preferring a free slot.
					s = $urandom_range(0, SLOTS - 1);
					if (held_hint != '1)
						while (held_hint[s]) s = $urandom_range(0, SLOTS - 1);
					send_event(CMD_KICK, 2'(s), 16'($urandom()), 1'($urandom()), $urandom());
				end else if (r < 70) begin
					// Content for a number that a slot is waiting on.
					if (held_hint != '0) begin
						s = $urandom_range(0, SLOTS - 1);
						while (!held_hint[s]) s = $urandom_range(0, SLOTS - 1);
						send_event(CMD_CONTENT, 2'(s), number_hint[s], 1'b1, $urandom());
					end else begin
						send_event(CMD_CONTENT, 2'd0, 16'($urandom()), 1'b1, $urandom());
					end
				end else if (r < 82) begin
					send_event(CMD_TIMEOUT, 2'($urandom()), 16'($urandom()), 1'($urandom()),
						$urandom());
				end else begin
					// Noise: any command with any fields.
					send_event(2'($urandom()), 2'($urandom()), 16'($urandom()),
						1'($urandom()), $urandom());
				end
				counted++;
			end
		end

		drain();
		if (waiting != 0)
			$error("%0d predicted results never arrived", waiting);
		if (fail_count == 0 && waiting == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
